// ===== design/dictionary_index_compactor_unit_assert.svh =====
// Assertion macros used by the compactor back end.
`ifndef DICTIONARY_INDEX_COMPACTOR_UNIT_ASSERT_SVH
`define DICTIONARY_INDEX_COMPACTOR_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define DIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/dic_pkg.sv =====
// ----------------------------------------------------------------------------
// dic_pkg
// Types and codes shared by the dictionary index compactor.
// ----------------------------------------------------------------------------
`default_nettype none
package dic_pkg;
  localparam int unsigned VAL_W  = 12;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SIZE_W = 13;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_ROW   = 2'd1,
    MODE_DLIST = 2'd2,
    MODE_XLIST = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VAL_W-1:0] index_value;
    logic [POS_W-1:0] position;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] dict_distinct;
    logic [CNT_W-1:0] extra_distinct;
    logic             out_of_range;
    logic             dropped;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/dictionary_index_compactor_unit.sv =====
// ----------------------------------------------------------------------------
// Dictionary index compactor: a two-entry queue feeds a back-end sequencer.
// Push: lookup, numbering (none when rows are full), output. Read: read, remap,
// numbering for row reads, output. A batch's first push clears the tables beforehand.
// Items run singly; busy is high while the queue is full; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module dictionary_index_compactor_unit #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned VALUE_RANGE = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire dic_pkg::in_item_t          in_item,
  output logic                            out_strobe,
  output dic_pkg::out_item_t              out_item,
  input  wire logic                       cfg_we,
  input  wire logic [dic_pkg::SIZE_W-1:0] cfg_wdata
);
  import dic_pkg::*;
  // Synchronous active-low reset closes the batch and zeroes counts and size.
  logic [SIZE_W-1:0] size_r;
  logic              full, nempty, pop;
  in_item_t          q;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= '0;
    else if (cfg_we) size_r <= cfg_wdata;
  end

  assign busy = full;

  dic_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(start && !busy), .din(in_item),
    .pop(pop), .dout(q), .not_empty(nempty), .full(full)
  );

  dic_back #(.MAX_ROWS(MAX_ROWS), .VALUE_RANGE(VALUE_RANGE)) u_back (
    .clk(clk), .rst_n(rst_n), .bound_size(size_r), .item_valid(nempty),
    .item(q), .item_pop(pop), .out_valid(out_strobe), .out_item(out_item)
  );
endmodule
`default_nettype wire

// ===== design/dic_fifo.sv =====
// ----------------------------------------------------------------------------
// dic_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module dic_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dic_pkg::in_item_t din,
  input  wire logic             pop,
  output dic_pkg::in_item_t     dout,
  output logic                  not_empty,
  output logic                  full
);
  import dic_pkg::*;
  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign dout      = mem_r[rp_r];
  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/dic_back.sv =====
// ----------------------------------------------------------------------------
// dic_back
// Executes pushes and reads against the stores; clears tables at batch start.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dictionary_index_compactor_unit_assert.svh"
module dic_back #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned VALUE_RANGE = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [dic_pkg::SIZE_W-1:0]  bound_size,
  input  wire logic                        item_valid,
  input  wire dic_pkg::in_item_t           item,
  output logic                             item_pop,
  output logic                             out_valid,
  output dic_pkg::out_item_t               out_item
);
  import dic_pkg::*;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned AW = $clog2(VALUE_RANGE);
  localparam int unsigned NW = $clog2(MAX_ROWS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_LOOK, S_NUM, S_READ, S_REMAP, S_OUT
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_r;
  logic [SIZE_W-1:0]  size_r;
  logic [NW-1:0]      rows_r, dcnt_r, xcnt_r;
  logic               open_r, drop_r;
  in_item_t           cur_r;
  logic [VAL_W-1:0]   val_r;
  logic               oor_r;

  logic [VAL_W-1:0]   rows_m [MAX_ROWS];
  logic [NW-1:0]      dtab_m [VALUE_RANGE];
  logic [NW-1:0]      xtab_m [VALUE_RANGE];
  logic [VAL_W-1:0]   dlist_m [MAX_ROWS];
  logic [VAL_W-1:0]   xlist_m [MAX_ROWS];

  logic [NW-1:0]      tab_q;
  logic [VAL_W-1:0]   rd_q;
  logic [SIZE_W-1:0]  key_r;   // value used for classification
  logic               isd_r;

  logic [SIZE_W-1:0]  shifted;
  logic [AW-1:0]      taddr;
  logic               full_rows;

  logic [SIZE_W-1:0]  lk_key;
  logic [SIZE_W-1:0]  lk_shift;
  logic               lk_isd;
  logic [AW-1:0]      lk_addr;
  logic [NW:0]        remap;

  assign item_pop  = item_valid && state_r == S_IDLE;
  assign shifted   = key_r - size_r;
  assign taddr     = isd_r ? key_r[AW-1:0] : shifted[AW-1:0];
  assign full_rows = rows_r == NW'(MAX_ROWS);

  // Lookup key: the pushed index, or the stored row when remapping a read.
  assign lk_key   = (state_r == S_REMAP) ? {1'b0, rd_q} : {1'b0, cur_r.index_value};
  assign lk_isd   = lk_key < size_r;
  assign lk_shift = lk_key - size_r;
  assign lk_addr  = lk_isd ? lk_key[AW-1:0] : lk_shift[AW-1:0];

  // A remap adds the dictionary count for extra keys.
  always_comb begin
    remap = '0;
    if (tab_q != '0) remap = isd_r ? {1'b0, tab_q} - 1'b1
                                   : {1'b0, tab_q} - 1'b1 + {1'b0, dcnt_r};
  end

  // Sequencer, counters and stores.
  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          cur_r <= item;
          if (mode_t'(item.mode) == MODE_PUSH) begin
            if (!open_r) begin
              clr_r <= '0; state_r <= S_CLEAR;
              rows_r <= '0; dcnt_r <= '0; xcnt_r <= '0;
              drop_r <= 1'b0; size_r <= bound_size; open_r <= 1'b1;
            end else begin
              state_r <= S_LOOK;
            end
          end else begin
            state_r <= S_READ;
          end
        end
      end
      S_CLEAR: begin
        dtab_m[clr_r] <= '0; xtab_m[clr_r] <= '0;
        clr_r <= clr_r + 1'b1;
        if (clr_r == AW'(VALUE_RANGE - 1)) state_r <= S_LOOK;
      end
      S_LOOK: begin
        key_r <= lk_key;
        isd_r <= lk_isd;
        tab_q <= lk_isd ? dtab_m[lk_addr] : xtab_m[lk_addr];
        if (full_rows) begin
          drop_r <= 1'b1;
          state_r <= S_OUT;
        end else begin
          rows_m[rows_r[RW-1:0]] <= cur_r.index_value;
          rows_r <= rows_r + 1'b1;
          state_r <= S_NUM;
        end
        oor_r <= 1'b0; val_r <= '0;
      end
      S_NUM: begin
        if (mode_t'(cur_r.mode) == MODE_ROW) begin
          val_r <= VAL_W'(remap);
        end else if (isd_r) begin
          if (tab_q == '0 && dcnt_r < NW'(MAX_ROWS)) begin
            dlist_m[dcnt_r[RW-1:0]] <= key_r[VAL_W-1:0];
            dtab_m[taddr] <= dcnt_r + 1'b1;
            dcnt_r <= dcnt_r + 1'b1;
          end
        end else begin
          if (tab_q == '0 && xcnt_r < NW'(MAX_ROWS)) begin
            xlist_m[xcnt_r[RW-1:0]] <= shifted[VAL_W-1:0];
            xtab_m[taddr] <= xcnt_r + 1'b1;
            xcnt_r <= xcnt_r + 1'b1;
          end
        end
        state_r <= S_OUT;
      end
      S_READ: begin
        val_r <= '0;
        unique case (mode_t'(cur_r.mode))
          MODE_ROW: begin
            oor_r <= NW'(cur_r.position) >= rows_r;
            rd_q  <= rows_m[cur_r.position[RW-1:0]];
          end
          MODE_DLIST: begin
            oor_r <= NW'(cur_r.position) >= dcnt_r;
            rd_q  <= dlist_m[cur_r.position[RW-1:0]];
          end
          default: begin
            oor_r <= NW'(cur_r.position) >= xcnt_r;
            rd_q  <= xlist_m[cur_r.position[RW-1:0]];
          end
        endcase
        state_r <= S_REMAP;
      end
      S_REMAP: begin
        if (mode_t'(cur_r.mode) == MODE_ROW && !oor_r) begin
          // Row remap: look up the stored index's number, resolve it next.
          key_r <= lk_key;
          isd_r <= lk_isd;
          tab_q <= lk_isd ? dtab_m[lk_addr] : xtab_m[lk_addr];
          state_r <= S_NUM;
        end else begin
          if (!oor_r) val_r <= rd_q;
          state_r <= S_OUT;
        end
      end
      default: begin
        state_r <= S_IDLE;
        if (mode_t'(cur_r.mode) != MODE_PUSH || cur_r.last) begin
          out_valid <= 1'b1;
          if (mode_t'(cur_r.mode) == MODE_PUSH) open_r <= 1'b0;
        end
      end
    endcase
    if (!rst_n) begin
      state_r <= S_IDLE; open_r <= 1'b0; drop_r <= 1'b0;
      rows_r <= '0; dcnt_r <= '0; xcnt_r <= '0; size_r <= '0;
      out_valid <= 1'b0;
    end
  end

  // Result fields.
  assign out_item = {val_r, CNT_W'(dcnt_r), CNT_W'(xcnt_r), oor_r, drop_r};

  `DIC_ASSERT_IMP(a_cnt_le_rows, clk, rst_n, 1'b1,
    {1'b0, dcnt_r} + {1'b0, xcnt_r} <= {1'b0, rows_r}, "distinct counts exceed rows")
  `DIC_ASSERT_NEXT(a_out_idle, clk, rst_n, out_valid, state_r == S_IDLE || state_r == S_READ
    || state_r == S_LOOK || state_r == S_CLEAR, "result not followed by idle")
  `DIC_ASSERT_IMP(a_pop_idle, clk, rst_n, item_pop, state_r == S_IDLE, "pop outside idle")
endmodule
`default_nettype wire

// ===== tb/sv/dictionary_index_compactor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dictionary index compactor checker
// Watches the command, result and configuration ports, predicts each result
// from its own copy of the batch state, and compares transactions in order.
// ----------------------------------------------------------------------------
module dictionary_index_compactor_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  dic_pkg::in_item_t          in_item,
  input  logic                       out_strobe,
  input  dic_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [dic_pkg::SIZE_W-1:0] cfg_wdata,
  output int                         errors,
  output int                         pending
);
  import dic_pkg::*;

  localparam int ROW_CAP   = 1024;
  localparam int KEY_SPACE = 4096;

  // Shadow of the block state.
  int unsigned  size_reg;
  int unsigned  size_held;
  logic [11:0]  rows [ROW_CAP];
  int unsigned  dict_num [KEY_SPACE];
  int unsigned  extra_num [KEY_SPACE];
  logic [11:0]  dict_keys [ROW_CAP];
  logic [11:0]  extra_keys [ROW_CAP];
  int unsigned  n_rows, n_dict, n_extra;
  bit           open_batch, drop_flag;

  out_item_t    expected_q[$];

  // Start a fresh batch: clear numbering and latch the boundary.
  task automatic open_new_batch();
    for (int i = 0; i < KEY_SPACE; i++) begin
      dict_num[i]  = 0;
      extra_num[i] = 0;
    end
    n_rows     = 0;
    n_dict     = 0;
    n_extra    = 0;
    drop_flag  = 0;
    size_held  = size_reg;
    open_batch = 1;
  endtask

  // Give a key its dense number on first sight.
  task automatic assign_number(input int unsigned key);
    int unsigned shifted;
    if (key < size_held) begin
      if (dict_num[key % KEY_SPACE] == 0 && n_dict < ROW_CAP) begin
        dict_keys[n_dict] = key[11:0];
        n_dict++;
        dict_num[key % KEY_SPACE] = n_dict;
      end
    end else begin
      shifted = key - size_held;
      if (extra_num[shifted % KEY_SPACE] == 0 && n_extra < ROW_CAP) begin
        extra_keys[n_extra] = shifted[11:0];
        n_extra++;
        extra_num[shifted % KEY_SPACE] = n_extra;
      end
    end
  endtask

  function automatic int unsigned renumbered_row(input int unsigned key);
    int unsigned n;
    if (key < size_held) begin
      n = dict_num[key % KEY_SPACE];
      return (n != 0) ? n - 1 : 0;
    end
    n = extra_num[(key - size_held) % KEY_SPACE];
    return (n != 0) ? n - 1 + n_dict : 0;
  endfunction

  // Apply one accepted command; queue a result when it produces one.
  task automatic apply_command(input in_item_t cmd);
    out_item_t   res;
    int unsigned pos;
    bit          gives_result;
    pos          = 32'(cmd.position);
    res          = '0;
    gives_result = 1;
    case (mode_t'(cmd.mode))
      MODE_PUSH: begin
        if (!open_batch) open_new_batch();
        if (n_rows < ROW_CAP) begin
          rows[n_rows] = cmd.index_value;
          n_rows++;
          assign_number(32'(cmd.index_value));
        end else begin
          drop_flag = 1;
        end
        if (cmd.last) open_batch = 0;
        else gives_result = 0;
      end
      MODE_ROW: begin
        if (pos < n_rows) res.value = VAL_W'(renumbered_row(32'(rows[pos])));
        else res.out_of_range = 1;
      end
      MODE_DLIST: begin
        if (pos < n_dict) res.value = dict_keys[pos];
        else res.out_of_range = 1;
      end
      default: begin
        if (pos < n_extra) res.value = extra_keys[pos];
        else res.out_of_range = 1;
      end
    endcase
    if (gives_result) begin
      res.dict_distinct  = CNT_W'(n_dict);
      res.extra_distinct = CNT_W'(n_extra);
      res.dropped        = drop_flag;
      expected_q.insert(expected_q.size(), res);
    end
  endtask

  // Compare a result transaction with the oldest expectation.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result value=%0d dd=%0d xd=%0d oor=%0b drop=%0b",
                 $realtime, got.value, got.dict_distinct, got.extra_distinct,
                 got.out_of_range, got.dropped);
      return;
    end
    want = expected_q.pop_front();
    if (got.value !== want.value || got.dict_distinct !== want.dict_distinct ||
        got.extra_distinct !== want.extra_distinct ||
        got.out_of_range !== want.out_of_range || got.dropped !== want.dropped) begin
      errors++;
      if (errors <= 10)
        $display({"%0t: mismatch exp value=%0d dd=%0d xd=%0d oor=%0b drop=%0b, ",
                  "got value=%0d dd=%0d xd=%0d oor=%0b drop=%0b"},
                 $realtime, want.value, want.dict_distinct, want.extra_distinct,
                 want.out_of_range, want.dropped, got.value, got.dict_distinct,
                 got.extra_distinct, got.out_of_range, got.dropped);
    end
  endtask

  // Sample all channels at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      errors     = 0;
      size_reg   = 0;
      size_held  = 0;
      n_rows     = 0;
      n_dict     = 0;
      n_extra    = 0;
      open_batch = 0;
      drop_flag  = 0;
      expected_q.delete();
    end else begin
      if (out_strobe) check_result(out_item);
      if (start && !busy) apply_command(in_item);
      if (cfg_we) size_reg = 32'(cfg_wdata);
    end
    pending = expected_q.size();
  end
endmodule

// ===== tb/sv/tb_dictionary_index_compactor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dictionary index compactor testbench
// Drives batches of index pushes and read commands under several dictionary
// sizes, with random sender gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_dictionary_index_compactor_unit;
  import dic_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [SIZE_W-1:0]    cfg_wdata;
  int                   errors;
  int                   pending;
  int                   stall_cycles;
  int                   sent;
  int                   gap_style;

  dictionary_index_compactor_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  dictionary_index_compactor_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: too long with no transaction on either channel ends the run.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[dictionary_index_compactor_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Issue one command and hold it until accepted, then maybe idle.
  task automatic issue(input mode_t mode, input int unsigned key,
                       input int unsigned pos, input bit last);
    int gap;
    @(negedge clk);
    start               <= 1'b1;
    in_item.mode        <= mode;
    in_item.index_value <= key[VAL_W-1:0];
    in_item.position    <= pos[POS_W-1:0];
    in_item.last        <= last;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent++;
    case (gap_style)
      0: gap = 0;
      1: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      default: gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 2);
    endcase
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Let every expected result arrive and the back end drain.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_dictionary_size(input int unsigned size);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= size[SIZE_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A batch of pushes, with optional reads while it is still open.
  task automatic push_batch(input int n, input int pool, input bit mid_reads);
    int unsigned key;
    for (int i = 0; i < n; i++) begin
      key = ($urandom_range(0, 1) == 0) ? $urandom_range(0, pool) : $urandom_range(0, 4095);
      issue(MODE_PUSH, key, $urandom_range(0, 1023), i == n - 1);
      if (mid_reads && $urandom_range(0, 9) == 0)
        issue(mode_t'($urandom_range(1, 3)), $urandom_range(0, 4095),
              $urandom_range(0, i + 2), $urandom_range(0, 1));
    end
  endtask

  task automatic read_back(input int count, input int n_rows);
    for (int i = 0; i < count; i++) begin
      issue(mode_t'($urandom_range(1, 3)), $urandom_range(0, 4095),
            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, n_rows + 1),
            $urandom_range(0, 1));
    end
  endtask

  initial begin
    int unsigned size;
    int          n;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    sent      = 0;
    gap_style = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reads before any batch, then a batch with repeats and both kinds.
    issue(MODE_ROW, 0, 0, 0);
    issue(MODE_DLIST, 0, 1023, 0);
    issue(MODE_XLIST, 0, 0, 0);
    set_dictionary_size(10);
    issue(MODE_PUSH, 0, 0, 0);
    issue(MODE_PUSH, 4095, 0, 0);
    issue(MODE_ROW, 0, 1, 0);
    issue(MODE_PUSH, 9, 0, 0);
    issue(MODE_PUSH, 10, 0, 0);
    issue(MODE_PUSH, 0, 0, 0);
    issue(MODE_PUSH, 4095, 0, 1);
    for (int p = 0; p < 6; p++) issue(MODE_ROW, 0, p, 0);
    issue(MODE_DLIST, 0, 1, 0);
    issue(MODE_XLIST, 0, 1, 0);
    issue(MODE_XLIST, 0, 2, 0);
    set_dictionary_size(4096);
    issue(MODE_PUSH, 4095, 0, 1);
    issue(MODE_ROW, 0, 0, 0);
    set_dictionary_size(0);
    issue(MODE_PUSH, 0, 0, 1);
    issue(MODE_XLIST, 0, 0, 0);

    // Random batches, one of them overflowing the row store.
    for (int b = 0; sent < 1200 || b < 6; b++) begin
      gap_style = $urandom_range(0, 2);
      case ($urandom_range(0, 5))
        0: size = 0;
        1: size = 4096;
        default: size = $urandom_range(0, 4096);
      endcase
      set_dictionary_size(size);
      n = (b == 3) ? 1030 : (($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 30));
      push_batch(n, $urandom_range(4, 4095), $urandom_range(0, 1));
      read_back($urandom_range(5, 25), (n > 1024) ? 1024 : n);
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("[dictionary_index_compactor_unit] OK");
    end else begin
      $display("[dictionary_index_compactor_unit] ERROR");
    end
    $finish;
  end
endmodule
